@@ src/solar_to_lunar_date_macros.svh @@
// shared assertion macros for the date converter
`ifndef SOLAR_TO_LUNAR_DATE_MACROS_SVH
`define SOLAR_TO_LUNAR_DATE_MACROS_SVH

// expression holds at every clock edge out of reset
`define S2L_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// antecedent implies consequent on the following edge
`define S2L_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/s2l_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2l_pkg
// types, year table and helpers shared by the date converter modules
// ----------------------------------------------------------------------------
package s2l_pkg;

    localparam int STORED_YEARS = 200;
    localparam logic [11:0] FIRST_YEAR = 12'd1900;
    // day number of 1900-01-31 on the internal scale
    localparam logic [22:0] BASE_DAYS = 23'd693931;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic year_step;
        logic month_init;
        logic month_step;
        logic done_ok;
        logic done_err;
    } t_dp_cmd;

    typedef struct packed {
        logic bad;
        logic year_hit;
        logic last_year;
        logic month_hit;
        logic month_end;
    } t_dp_sts;

    localparam logic [16:0] YEAR_WORDS [0:199] = '{
        17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260, 17'h0d950, 17'h16554, 17'h056a0,
        17'h09ad0, 17'h055d2, 17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250, 17'h1d255, 17'h0b540,
        17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977, 17'h04970, 17'h0a4b0, 17'h0b4b5, 17'h06a50,
        17'h06d40, 17'h1ab54, 17'h02b60, 17'h09570, 17'h052f2, 17'h04970, 17'h06566, 17'h0d4a0,
        17'h0ea50, 17'h06e95, 17'h05ad0, 17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950,
        17'h0d4a0, 17'h1d8a6, 17'h0b550, 17'h056a0, 17'h1a5b4, 17'h025d0, 17'h092d0, 17'h0d2b2,
        17'h0a950, 17'h0b557, 17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5b0, 17'h14573,
        17'h052b0, 17'h0a9a8, 17'h0e950, 17'h06aa0, 17'h0aea6, 17'h0ab50, 17'h04b60, 17'h0aae4,
        17'h0a570, 17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0, 17'h096d0, 17'h04dd5,
        17'h04ad0, 17'h0a4d0, 17'h0d4d4, 17'h0d250, 17'h0d558, 17'h0b540, 17'h0b6a0, 17'h195a6,
        17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0, 17'h0b27a, 17'h06a50, 17'h06d40, 17'h0af46,
        17'h0ab60, 17'h09570, 17'h04af5, 17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50, 17'h06b58,
        17'h055c0, 17'h0ab60, 17'h096d5, 17'h092e0, 17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50,
        17'h07552, 17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5, 17'h0a950, 17'h0b4a0,
        17'h0baa4, 17'h0ad50, 17'h055d9, 17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0, 17'h0a930,
        17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60, 17'h0a6e6, 17'h0a4e0, 17'h0d260,
        17'h0ea65, 17'h0d530, 17'h05aa0, 17'h076a3, 17'h096d0, 17'h04bd7, 17'h04ad0, 17'h0a4d0,
        17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45, 17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0,
        17'h0a577, 17'h0a4b0, 17'h0aa50, 17'h1b255, 17'h06d20, 17'h0ada0, 17'h14b63, 17'h09370,
        17'h049f8, 17'h04970, 17'h064b0, 17'h168a6, 17'h0ea50, 17'h06b20, 17'h1a6c4, 17'h0aae0,
        17'h0a2e0, 17'h0d2e3, 17'h0c960, 17'h0d557, 17'h0d4a0, 17'h0da50, 17'h05d55, 17'h056a0,
        17'h0a6d0, 17'h055d4, 17'h052d0, 17'h0a9b8, 17'h0a950, 17'h0b4a0, 17'h0b6a6, 17'h0ad50,
        17'h055a0, 17'h0aba4, 17'h0a5b0, 17'h052b0, 17'h0b273, 17'h06930, 17'h07337, 17'h06aa0,
        17'h0ad50, 17'h14b55, 17'h04b60, 17'h0a570, 17'h054e4, 17'h0d160, 17'h0e968, 17'h0d520,
        17'h0daa0, 17'h16aa6, 17'h056d0, 17'h04ae0, 17'h0a9d4, 17'h0a2d0, 17'h0d150, 17'h0f252
    };

    function automatic logic [16:0] year_word(input logic [7:0] idx);
        logic [16:0] w;
        w = '0;
        if (idx < 8'd200) begin
            w = YEAR_WORDS[idx];
        end
        return w;
    endfunction

    // days from march 1 to the first of the month, month counted from march
    function automatic logic [8:0] days_before(input logic [3:0] mm);
        logic [8:0] d;
        case (mm)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            default: d = 9'd337;
        endcase
        return d;
    endfunction

    function automatic logic [3:0] leap_of(input logic [16:0] w);
        logic [3:0] l;
        l = (w[3:0] <= 4'd12) ? w[3:0] : 4'd0;
        return l;
    endfunction

    function automatic logic [8:0] year_len(input logic [16:0] w);
        logic [8:0] s;
        s = 9'd348;
        for (int b = 4; b < 16; b++) begin
            s = s + {8'd0, w[b]};
        end
        if (leap_of(w) != 4'd0) begin
            s = s + (w[16] ? 9'd30 : 9'd29);
        end
        return s;
    endfunction

endpackage

@@ src/s2l_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2l_ctrl
// sequencer: date to day count, then year walk, then month walk
// ----------------------------------------------------------------------------
`include "solar_to_lunar_date_macros.svh"

module s2l_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  s2l_pkg::t_dp_sts i_sts,
    output s2l_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_YEAR  = 3'd3;
    localparam logic [2:0] ST_MONTH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_YEAR;
            end
            ST_YEAR: begin
                if (i_sts.bad) begin
                    o_cmd.done_err = 1'b1;
                    n_state        = ST_IDLE;
                end else if (i_sts.year_hit) begin
                    o_cmd.month_init = 1'b1;
                    n_state          = ST_MONTH;
                end else if (i_sts.last_year) begin
                    o_cmd.done_err = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            ST_MONTH: begin
                if (i_sts.month_hit) begin
                    o_cmd.done_ok = 1'b1;
                    n_state       = ST_IDLE;
                end else if (i_sts.month_end) begin
                    o_cmd.done_err = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    `S2L_ASSERT(a_done_excl, !(o_cmd.done_ok && o_cmd.done_err), "both done commands")
    `S2L_ASSERT_NEXT(a_done_idle, o_cmd.done_ok || o_cmd.done_err, r_state == ST_IDLE, "not idle")
    `S2L_ASSERT_NEXT(a_load_mul, o_cmd.load, r_state == ST_MUL, "load not followed by mul")

endmodule

@@ src/s2l_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2l_dp
// datapath: day count arithmetic, year and month walkers, result registers
// ----------------------------------------------------------------------------
module s2l_dp #(
    parameter int TABLE_YEARS = 200
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [11:0]      i_solar_year,
    input  logic [3:0]       i_solar_month,
    input  logic [4:0]       i_solar_day,
    input  s2l_pkg::t_dp_cmd i_cmd,
    output s2l_pkg::t_dp_sts o_sts,
    output logic             o_valid,
    output logic [11:0]      o_lunar_year,
    output logic [3:0]       o_lun_month,
    output logic [4:0]       o_lun_day,
    output logic             o_is_leap_month,
    output logic             o_out_of_range
);

    localparam int YEARS_USED =
        (TABLE_YEARS < s2l_pkg::STORED_YEARS) ? TABLE_YEARS : s2l_pkg::STORED_YEARS;
    localparam logic [7:0] LAST_IDX = 8'(YEARS_USED - 1);

    logic [12:0] r_y2;
    logic [3:0]  r_mm;
    logic [4:0]  r_day;
    logic        r_early;
    logic        r_bad;
    logic [20:0] r_p365;
    logic [25:0] r_q;
    logic [20:0] r_off;
    logic [7:0]  r_yi;
    logic [16:0] r_word;
    logic [3:0]  r_mo;
    logic        r_in_leap;
    logic        r_valid;

    // month normalisation
    logic [12:0] y1;
    logic [3:0]  m1;
    logic        early;
    always_comb begin
        y1 = {1'b0, i_solar_year};
        m1 = i_solar_month;
        if (i_solar_month == 4'd0) begin
            y1 = {1'b0, i_solar_year} - 13'd1;
            m1 = 4'd12;
        end else if (i_solar_month >= 4'd13) begin
            y1 = {1'b0, i_solar_year} + 13'd1;
            m1 = i_solar_month - 4'd12;
        end
        early = ((i_solar_month == 4'd0) && (i_solar_year == 12'd0))
              || (y1 < 13'd1900);
    end

    logic [22:0] sum;
    always_comb begin
        sum = 23'(r_p365) + 23'(r_y2[12:2]) - 23'(r_q[25:19]) + 23'(r_q[25:21])
            + 23'(s2l_pkg::days_before(r_mm)) + 23'(r_day) - 23'd1 - s2l_pkg::BASE_DAYS;
    end

    logic [16:0] word;
    logic [8:0]  ylen;
    assign word = s2l_pkg::year_word(r_yi);
    assign ylen = s2l_pkg::year_len(word);

    logic [3:0] lp;
    logic [4:0] bit_idx;
    logic [4:0] mlen;
    logic       enter_leap;
    assign lp         = s2l_pkg::leap_of(r_word);
    assign bit_idx    = 5'd16 - {1'b0, r_mo};
    assign mlen       = r_in_leap ? (r_word[16] ? 5'd30 : 5'd29)
                                  : (r_word[bit_idx] ? 5'd30 : 5'd29);
    assign enter_leap = !r_in_leap && (r_mo == lp);

    always_comb begin
        o_sts           = '0;
        o_sts.bad       = r_bad;
        o_sts.year_hit  = (r_off < 21'(ylen));
        o_sts.last_year = (r_yi == LAST_IDX);
        o_sts.month_hit = (r_off < 21'(mlen));
        o_sts.month_end = !enter_leap && (r_mo == 4'd12);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_y2    <= (m1 <= 4'd2) ? (y1 - 13'd1) : y1;
            r_mm    <= (m1 > 4'd2) ? (m1 - 4'd3) : (m1 + 4'd9);
            r_day   <= i_solar_day;
            r_early <= early;
            r_yi    <= '0;
        end
        if (i_cmd.mul) begin
            r_p365 <= 21'(r_y2) * 21'd365;
            r_q    <= 26'(r_y2) * 26'd5243;
        end
        if (i_cmd.sum) begin
            r_off <= sum[20:0];
            r_bad <= r_early || sum[22];
        end
        if (i_cmd.year_step) begin
            r_off <= r_off - 21'(ylen);
            r_yi  <= r_yi + 8'd1;
        end
        if (i_cmd.month_init) begin
            r_word    <= word;
            r_mo      <= 4'd1;
            r_in_leap <= 1'b0;
        end
        if (i_cmd.month_step) begin
            r_off <= r_off - 21'(mlen);
            if (enter_leap) begin
                r_in_leap <= 1'b1;
            end else begin
                r_in_leap <= 1'b0;
                r_mo      <= r_mo + 4'd1;
            end
        end
        if (i_cmd.done_ok) begin
            o_lunar_year    <= s2l_pkg::FIRST_YEAR + {4'd0, r_yi};
            o_lun_month     <= r_mo;
            o_lun_day       <= r_off[4:0] + 5'd1;
            o_is_leap_month <= r_in_leap;
            o_out_of_range  <= 1'b0;
        end else if (i_cmd.done_err) begin
            o_lunar_year    <= '0;
            o_lun_month     <= '0;
            o_lun_day       <= '0;
            o_is_leap_month <= 1'b0;
            o_out_of_range  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.done_ok || i_cmd.done_err;
        end
    end

    assign o_valid = r_valid;

endmodule

@@ src/solar_to_lunar_date.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// solar_to_lunar_date
// gregorian date to chinese lunar date over a table of lunar year words
// ----------------------------------------------------------------------------
// usage
//   request channel: drive i_solar_year, i_solar_month, i_solar_day and raise
//   start; the request is taken on a rising edge with start high and busy low
//   result channel: o_valid is high for exactly one cycle with the lunar date
//   on o_lunar_year, o_lun_month, o_lun_day, o_is_leap_month, o_out_of_range;
//   the receiver cannot hold results off, so take it then
//   sequence: after the request edge the block runs multiply, sum, one year step
//   per lunar year walked from 1900 (0 to 199), month start, one month step per
//   month walked (0 to 12), month hit and the result register; a date before
//   the table errors right after the sum, one past it after the last year word
//   throughput: one request at a time, busy stays high until the walk ends,
//   so a new request is taken on the edge that takes the result
//   the year walk over the constant table is the longest part of the sequence
//   out of range dates are reported with o_out_of_range and zero fields
//   reset clears the sequencer and the result strobe; no clearing pass
// ----------------------------------------------------------------------------
`include "solar_to_lunar_date_macros.svh"

module solar_to_lunar_date #(
    parameter int TABLE_YEARS = 200
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] i_solar_year,
    input  logic [3:0]  i_solar_month,
    input  logic [4:0]  i_solar_day,
    output logic        o_valid,
    output logic [11:0] o_lunar_year,
    output logic [3:0]  o_lun_month,
    output logic [4:0]  o_lun_day,
    output logic        o_is_leap_month,
    output logic        o_out_of_range
);

    s2l_pkg::t_dp_cmd cmd;
    s2l_pkg::t_dp_sts sts;

    // sequencer
    s2l_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // arithmetic, table walk and result registers
    s2l_dp #(
        .TABLE_YEARS (TABLE_YEARS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_solar_year    (i_solar_year),
        .i_solar_month   (i_solar_month),
        .i_solar_day     (i_solar_day),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_lunar_year    (o_lunar_year),
        .o_lun_month     (o_lun_month),
        .o_lun_day       (o_lun_day),
        .o_is_leap_month (o_is_leap_month),
        .o_out_of_range  (o_out_of_range)
    );

    // result fields in their legal ranges, or all zero
    logic fields_sane;
    logic fields_zero;
    assign fields_sane = (o_lun_month != 4'd0) && (o_lun_month <= 4'd12)
                       && (o_lun_day != 5'd0) && (o_lun_day <= 5'd30);
    assign fields_zero = (o_lunar_year == 12'd0) && (o_lun_month == 4'd0)
                       && (o_lun_day == 5'd0) && !o_is_leap_month;

    // a good result carries a real month and day
    `S2L_ASSERT(a_ok_fields, !(o_valid && !o_out_of_range) || fields_sane, "bad result fields")
    // an error result carries zero fields
    `S2L_ASSERT(a_err_zero, !(o_valid && o_out_of_range) || fields_zero, "error fields not zero")
    // no result follows an idle cycle without a request
    `S2L_ASSERT_NEXT(a_idle_quiet, !busy && !start, !o_valid, "result without request")

endmodule

@@ verif/solar_to_lunar_date_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// solar_to_lunar_date_checker
// watches the request and result channels of the date converter, works out
// the lunar date of every accepted request and compares each result with it
// ----------------------------------------------------------------------------
module solar_to_lunar_date_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [11:0] i_solar_year,
    input  logic [3:0]  i_solar_month,
    input  logic [4:0]  i_solar_day,
    input  logic        i_valid,
    input  logic [11:0] i_lunar_year,
    input  logic [3:0]  i_lun_month,
    input  logic [4:0]  i_lun_day,
    input  logic        i_is_leap_month,
    input  logic        i_out_of_range,
    output int          o_fails,
    output int          o_pending
);

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        leap;
        logic        oor;
    } t_lunar_date;

    localparam int NUM_YEARS = 200;

    // lunar year words from 1900 on
    localparam logic [16:0] LUNAR_WORDS [0:199] = '{
        17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260, 17'h0d950, 17'h16554, 17'h056a0,
        17'h09ad0, 17'h055d2, 17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250, 17'h1d255, 17'h0b540,
        17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977, 17'h04970, 17'h0a4b0, 17'h0b4b5, 17'h06a50,
        17'h06d40, 17'h1ab54, 17'h02b60, 17'h09570, 17'h052f2, 17'h04970, 17'h06566, 17'h0d4a0,
        17'h0ea50, 17'h06e95, 17'h05ad0, 17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950,
        17'h0d4a0, 17'h1d8a6, 17'h0b550, 17'h056a0, 17'h1a5b4, 17'h025d0, 17'h092d0, 17'h0d2b2,
        17'h0a950, 17'h0b557, 17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5b0, 17'h14573,
        17'h052b0, 17'h0a9a8, 17'h0e950, 17'h06aa0, 17'h0aea6, 17'h0ab50, 17'h04b60, 17'h0aae4,
        17'h0a570, 17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0, 17'h096d0, 17'h04dd5,
        17'h04ad0, 17'h0a4d0, 17'h0d4d4, 17'h0d250, 17'h0d558, 17'h0b540, 17'h0b6a0, 17'h195a6,
        17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0, 17'h0b27a, 17'h06a50, 17'h06d40, 17'h0af46,
        17'h0ab60, 17'h09570, 17'h04af5, 17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50, 17'h06b58,
        17'h055c0, 17'h0ab60, 17'h096d5, 17'h092e0, 17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50,
        17'h07552, 17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5, 17'h0a950, 17'h0b4a0,
        17'h0baa4, 17'h0ad50, 17'h055d9, 17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0, 17'h0a930,
        17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60, 17'h0a6e6, 17'h0a4e0, 17'h0d260,
        17'h0ea65, 17'h0d530, 17'h05aa0, 17'h076a3, 17'h096d0, 17'h04bd7, 17'h04ad0, 17'h0a4d0,
        17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45, 17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0,
        17'h0a577, 17'h0a4b0, 17'h0aa50, 17'h1b255, 17'h06d20, 17'h0ada0, 17'h14b63, 17'h09370,
        17'h049f8, 17'h04970, 17'h064b0, 17'h168a6, 17'h0ea50, 17'h06b20, 17'h1a6c4, 17'h0aae0,
        17'h0a2e0, 17'h0d2e3, 17'h0c960, 17'h0d557, 17'h0d4a0, 17'h0da50, 17'h05d55, 17'h056a0,
        17'h0a6d0, 17'h055d4, 17'h052d0, 17'h0a9b8, 17'h0a950, 17'h0b4a0, 17'h0b6a6, 17'h0ad50,
        17'h055a0, 17'h0aba4, 17'h0a5b0, 17'h052b0, 17'h0b273, 17'h06930, 17'h07337, 17'h06aa0,
        17'h0ad50, 17'h14b55, 17'h04b60, 17'h0a570, 17'h054e4, 17'h0d160, 17'h0e968, 17'h0d520,
        17'h0daa0, 17'h16aa6, 17'h056d0, 17'h04ae0, 17'h0a9d4, 17'h0a2d0, 17'h0d150, 17'h0f252
    };

    t_lunar_date lunar_expected [$];

    // day number of the first of a month, civil calendar
    function automatic longint month_start_day(input longint yr, input longint mon);
        longint y, era, yoe, doy;
        y = (mon <= 2) ? yr - 1 : yr;
        era = ((y >= 0) ? y : y - 399) / 400;
        yoe = y - era * 400;
        doy = (153 * ((mon > 2) ? mon - 3 : mon + 9) + 2) / 5;
        return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
    endfunction

    function automatic t_lunar_date convert_date(input logic [11:0] sy, input logic [3:0] sm,
                                                 input logic [4:0] sd);
        t_lunar_date r;
        longint mi, y, m, off, len;
        logic [16:0] w;
        int lp, yi;
        r = '{year: 12'd0, month: 4'd0, day: 5'd0, leap: 1'b0, oor: 1'b1};
        mi = longint'(sy) * 12 + longint'(sm) - 1;
        if (mi < 0) begin
            y = -1;
            m = 12;
        end else begin
            y = mi / 12;
            m = mi % 12 + 1;
        end
        off = month_start_day(y, m) + longint'(sd) - 1 - (month_start_day(1900, 1) + 30);
        if (off < 0) return r;
        for (yi = 0; yi < NUM_YEARS; yi++) begin
            w = LUNAR_WORDS[yi];
            len = 348;
            for (int b = 4; b < 16; b++) len += w[b];
            if (w[3:0] != 4'd0 && w[3:0] <= 4'd12) len += w[16] ? 30 : 29;
            if (off < len) break;
            off -= len;
        end
        if (yi >= NUM_YEARS) return r;
        w = LUNAR_WORDS[yi];
        lp = (w[3:0] <= 4'd12) ? int'(w[3:0]) : 0;
        for (int mo = 1; mo <= 12; mo++) begin
            len = w[16 - mo] ? 30 : 29;
            if (off < len) begin
                return '{year: 12'(1900 + yi), month: 4'(mo), day: 5'(off + 1),
                         leap: 1'b0, oor: 1'b0};
            end
            off -= len;
            if (mo == lp) begin
                len = w[16] ? 30 : 29;
                if (off < len) begin
                    return '{year: 12'(1900 + yi), month: 4'(mo), day: 5'(off + 1),
                             leap: 1'b1, oor: 1'b0};
                end
                off -= len;
            end
        end
        return r;
    endfunction

    assign o_pending = lunar_expected.size();

    always @(posedge i_clk) begin
        t_lunar_date exp_date;
        if (!i_rst_n) begin
            o_fails <= 0;
        end else begin
            if (i_valid) begin
                if (lunar_expected.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fails <= o_fails + 1;
                end else begin
                    exp_date = lunar_expected.pop_front();
                    if (i_lunar_year !== exp_date.year || i_lun_month !== exp_date.month
                            || i_lun_day !== exp_date.day || i_is_leap_month !== exp_date.leap
                            || i_out_of_range !== exp_date.oor) begin
                        o_fails <= o_fails + 1;
                    end
                    if (i_lunar_year !== exp_date.year)
                        $error("lunar_year expected %0d got %0d", exp_date.year, i_lunar_year);
                    if (i_lun_month !== exp_date.month)
                        $error("lun_month expected %0d got %0d", exp_date.month, i_lun_month);
                    if (i_lun_day !== exp_date.day)
                        $error("lun_day expected %0d got %0d", exp_date.day, i_lun_day);
                    if (i_is_leap_month !== exp_date.leap)
                        $error("is_leap_month expected %0d got %0d", exp_date.leap,
                               i_is_leap_month);
                    if (i_out_of_range !== exp_date.oor)
                        $error("out_of_range expected %0d got %0d", exp_date.oor,
                               i_out_of_range);
                end
            end
            if (i_start && !i_busy) begin
                lunar_expected.push_back(convert_date(i_solar_year, i_solar_month, i_solar_day));
            end
        end
    end

endmodule

@@ verif/solar_to_lunar_date_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// solar_to_lunar_date_test
// drives gregorian dates into the converter: a directed set of edge dates,
// then random dates, mostly in the table's span with some out of range and
// raw bit patterns; a checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module solar_to_lunar_date_test;

    localparam int NUM_RANDOM = 1100;
    // cycles without any request or result before giving up
    localparam int STALL_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [11:0] i_solar_year;
    logic [3:0]  i_solar_month;
    logic [4:0]  i_solar_day;
    logic        o_valid;
    logic [11:0] o_lunar_year;
    logic [3:0]  o_lun_month;
    logic [4:0]  o_lun_day;
    logic        o_is_leap_month;
    logic        o_out_of_range;
    int          fails;
    int          pending;
    int          quiet_cycles;
    bit          calm_stretch;

    solar_to_lunar_date dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_solar_year(i_solar_year), .i_solar_month(i_solar_month),
        .i_solar_day(i_solar_day), .o_valid(o_valid), .o_lunar_year(o_lunar_year),
        .o_lun_month(o_lun_month), .o_lun_day(o_lun_day),
        .o_is_leap_month(o_is_leap_month), .o_out_of_range(o_out_of_range)
    );

    solar_to_lunar_date_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_solar_year(i_solar_year), .i_solar_month(i_solar_month),
        .i_solar_day(i_solar_day), .i_valid(o_valid), .i_lunar_year(o_lunar_year),
        .i_lun_month(o_lun_month), .i_lun_day(o_lun_day),
        .i_is_leap_month(o_is_leap_month), .i_out_of_range(o_out_of_range),
        .o_fails(fails), .o_pending(pending)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog on cycles where neither a request nor a result moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[solar_to_lunar_date] ERROR");
                $finish;
            end
        end
    end

    // issue one request; runs from a rising edge and returns on the edge that takes it
    task automatic send_date(input logic [11:0] yr, input logic [3:0] mon, input logic [4:0] dd);
        if (!calm_stretch && $urandom_range(99) < 7) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
        i_solar_year  <= yr;
        i_solar_month <= mon;
        i_solar_day   <= dd;
        start         <= 1'b1;
        forever begin
            // busy only moves on rising edges, so the falling edge sees it settled
            @(negedge i_clk);
            if (!busy) begin
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
    endtask

    initial begin
        int pick;
        calm_stretch  = 1'b0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_solar_year  = '0;
        i_solar_month = '0;
        i_solar_day   = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: table start and end, rolled months and days, leap months
        send_date(12'd1900, 4'd1, 5'd31);   // first convertible day
        send_date(12'd1900, 4'd1, 5'd30);   // one day too early
        send_date(12'd1900, 4'd2, 5'd0);    // day 0 rolls back to jan 31
        send_date(12'd0, 4'd0, 5'd0);
        send_date(12'd4095, 4'd15, 5'd31);
        send_date(12'd1900, 4'd0, 5'd31);   // month 0 is december before
        send_date(12'd1999, 4'd13, 5'd1);   // month past december rolls on
        send_date(12'd2000, 4'd15, 5'd31);
        send_date(12'd2023, 4'd2, 5'd31);   // overlong february
        send_date(12'd2020, 4'd5, 5'd23);   // leap fourth month
        send_date(12'd2020, 4'd6, 5'd20);
        send_date(12'd2020, 4'd6, 5'd21);
        send_date(12'd2023, 4'd3, 5'd22);   // leap second month
        send_date(12'd2023, 4'd4, 5'd19);
        send_date(12'd2017, 4'd7, 5'd23);   // leap sixth month
        send_date(12'd2033, 4'd12, 5'd22);  // late 2033; the table word gives that year a leap seventh month
        send_date(12'd2100, 4'd1, 5'd1);
        send_date(12'd2100, 4'd1, 5'd31);
        send_date(12'd2100, 4'd2, 5'd9);    // around the end of the table
        send_date(12'd2100, 4'd2, 5'd10);
        send_date(12'd2100, 4'd12, 5'd31);
        send_date(12'd1984, 4'd2, 5'd2);
        send_date(12'd1899, 4'd12, 5'd31);

        // random: calm stretch in the middle with no gaps
        for (int n = 0; n < NUM_RANDOM; n++) begin
            calm_stretch = (n >= 400 && n < 650);
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_date(12'($urandom_range(1900, 2100)), 4'($urandom_range(1, 12)),
                          5'($urandom_range(1, 31)));
            end else if (pick < 90) begin
                send_date(12'($urandom_range(1898, 2101)), 4'($urandom_range(0, 15)),
                          5'($urandom_range(0, 31)));
            end else begin
                send_date(12'($urandom), 4'($urandom), 5'($urandom));
            end
        end
        start <= 1'b0;

        // drain; the watchdog covers a hang here
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fails == 0 && pending == 0) begin
            $display("[solar_to_lunar_date] OK");
        end else begin
            $display("[solar_to_lunar_date] ERROR");
        end
        $finish;
    end

endmodule
